// ===== rtl/tedec_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tedec_pkg: shared types and constants of the text escape decoder
// Decoder modes, entity tables, character codes and the command record that
// travels from the classifier to the beat generator.
// ----------------------------------------------------------------------------
package tedec_pkg;

   localparam int ENTITY_MAX_LEN = 5;   // entity letters held after '&'
   localparam int NUM_ENT        = 5;   // number of recognized entities
   localparam int CMD_BYTES      = 6;   // most data bytes one input byte yields
   localparam int PCNT_W         = 3;   // held letters or hex digits taken
   localparam int BCNT_W         = 3;   // data byte count of one command

   typedef enum logic [2:0] {
      M_NORMAL,
      M_ENTITY,
      M_ESCAPE,
      M_HEX1,
      M_SURR_BS,
      M_SURR_U,
      M_HEX2,
      M_FAILED
   } mode_type;

   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_AMP    = 8'h26;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_LC_B   = 8'h62;
   localparam logic [7:0] CH_LC_F   = 8'h66;
   localparam logic [7:0] CH_LC_N   = 8'h6E;
   localparam logic [7:0] CH_LC_R   = 8'h72;
   localparam logic [7:0] CH_LC_T   = 8'h74;
   localparam logic [7:0] CH_LC_U   = 8'h75;
   localparam logic [7:0] CH_BS     = 8'h08;
   localparam logic [7:0] CH_FF     = 8'h0C;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_TAB    = 8'h09;

   // quot; apos; amp; lt; gt; (unused tail positions are zero)
   localparam logic [7:0] ENT_PAT [NUM_ENT][ENTITY_MAX_LEN] = '{
      '{8'h71, 8'h75, 8'h6F, 8'h74, 8'h3B},
      '{8'h61, 8'h70, 8'h6F, 8'h73, 8'h3B},
      '{8'h61, 8'h6D, 8'h70, 8'h3B, 8'h00},
      '{8'h6C, 8'h74, 8'h3B, 8'h00, 8'h00},
      '{8'h67, 8'h74, 8'h3B, 8'h00, 8'h00}
   };
   localparam logic [PCNT_W-1:0] ENT_LEN [NUM_ENT] = '{3'd5, 3'd5, 3'd4, 3'd3, 3'd3};
   localparam logic [7:0] ENT_VAL [NUM_ENT] = '{8'h22, 8'h27, 8'h26, 8'h3C, 8'h3E};

   typedef struct packed {
      logic [CMD_BYTES-1:0][7:0] bytes;
      logic [BCNT_W-1:0]         count;
      logic                      is_end;
      logic                      error;
      logic [15:0]               length;
   } cmd_type;

endpackage

// ===== rtl/tedec_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tedec_if: channel interfaces of the text escape decoder
// Source byte channel and decoded result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface tedec_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       in_last;

   modport source (output valid, output in_byte, output in_last, input ready);
   modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface tedec_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  out_byte;
   logic        is_end;
   logic        error;
   logic [15:0] out_length;

   modport source (output valid, output out_byte, output is_end, output error,
                   output out_length, input ready);
   modport sink   (input valid, input out_byte, input is_end, input error,
                   input out_length, output ready);
endinterface

// ===== rtl/tedec_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tedec_front: byte classifier
// Runs the escape and entity state machine on each accepted byte; each byte
// with output or in_last pushes a command: its bytes and, if last, end status.
// ----------------------------------------------------------------------------
module tedec_front (
   input  logic                 clock,
   input  logic                 reset,
   tedec_req_if.sink            req,
   input  logic                 csr_wr_en,
   input  logic [15:0]          csr_wr_data,
   input  logic                 q_full,
   output logic                 push,
   output tedec_pkg::cmd_type   push_cmd
);
   import tedec_pkg::*;

   function automatic logic [7:0] to_lower(logic [7:0] ch);
      to_lower = (ch >= 8'h41 && ch <= 8'h5A) ? ch + 8'd32 : ch;
   endfunction

   // {valid, value}
   function automatic logic [4:0] hex_digit(logic [7:0] ch);
      logic [7:0] t;
      t = 8'h00;
      if (ch >= 8'h30 && ch <= 8'h39) begin
         t = ch - 8'h30;
         hex_digit = {1'b1, t[3:0]};
      end else if (ch >= 8'h41 && ch <= 8'h46) begin
         t = ch - 8'h37;
         hex_digit = {1'b1, t[3:0]};
      end else if (ch >= 8'h61 && ch <= 8'h66) begin
         t = ch - 8'h57;
         hex_digit = {1'b1, t[3:0]};
      end else begin
         hex_digit = 5'd0;
      end
   endfunction

   mode_type              mode_ff, mode_in;
   logic [PCNT_W-1:0]     pcnt_ff, pcnt_in;
   logic [7:0]            pend_ff [ENTITY_MAX_LEN];
   logic [7:0]            pend_in [ENTITY_MAX_LEN];
   logic [15:0]           hex_ff, hex_in;
   logic [9:0]            hsur_ff, hsur_in;
   logic [15:0]           wcnt_ff, wcnt_in;
   logic [15:0]           cap_ff;

   logic [7:0]            c;
   logic                  last;
   logic                  accept;
   logic                  active;
   logic [PCNT_W-1:0]     n_ent;
   logic [NUM_ENT-1:0]    ent_ok;
   logic [NUM_ENT-1:0]    ent_full;
   logic [7:0]            ent_b;
   logic [7:0]            ent_hit;
   logic [4:0]            hex_v;
   logic [15:0]           acc;
   logic [20:0]           utf_cp;
   logic                  utf_go;
   logic [CMD_BYTES-1:0][7:0] cand;
   logic [BCNT_W-1:0]     ncand;
   logic [15:0]           room;
   logic [BCNT_W-1:0]     emitted;
   logic [15:0]           wcnt_sum;
   logic                  fail_end;

   assign c         = req.in_byte;
   assign last      = req.in_last;
   assign req.ready = !q_full;
   assign accept    = req.valid && req.ready;
   assign active    = (mode_ff != M_FAILED) && (wcnt_ff < cap_ff);
   assign n_ent     = pcnt_ff + 3'd1;
   assign hex_v     = hex_digit(c);
   assign acc       = {hex_ff[11:0], hex_v[3:0]};

   // entity prefix match over held letters plus the new byte
   always_comb begin
      ent_b   = 8'h00;
      ent_hit = 8'h00;
      for (int i = 0; i < NUM_ENT; i++) begin
         ent_ok[i] = (n_ent <= ENT_LEN[i]);
         for (int k = 0; k < ENTITY_MAX_LEN; k++) begin
            if (PCNT_W'(k) < n_ent) begin
               ent_b = (PCNT_W'(k) < pcnt_ff) ? pend_ff[k] : c;
               if (k == 0) begin
                  if (ent_b != ENT_PAT[i][k]) ent_ok[i] = 1'b0;
               end else if (to_lower(ent_b) != ENT_PAT[i][k]) begin
                  ent_ok[i] = 1'b0;
               end
            end
         end
         ent_full[i] = ent_ok[i] && (n_ent == ENT_LEN[i]);
         if (ent_full[i]) ent_hit = ENT_VAL[i];
      end
   end

   always_comb begin
      mode_in = mode_ff;
      pcnt_in = pcnt_ff;
      pend_in = pend_ff;
      hex_in  = hex_ff;
      hsur_in = hsur_ff;
      cand    = '0;
      ncand   = '0;
      utf_cp  = '0;
      utf_go  = 1'b0;
      if (active) begin
         unique case (mode_ff)
            M_NORMAL: begin
               if (c == CH_BSLASH && !last) begin
                  mode_in = M_ESCAPE;
               end else if (c == CH_AMP && !last) begin
                  mode_in = M_ENTITY;
                  pcnt_in = '0;
               end else begin
                  cand[0] = c;
                  ncand   = 3'd1;
               end
            end
            M_ENTITY: begin
               if (|ent_full) begin
                  cand[0] = ent_hit;
                  ncand   = 3'd1;
                  mode_in = M_NORMAL;
                  pcnt_in = '0;
               end else if (|ent_ok && !last) begin
                  pend_in[pcnt_ff] = c;
                  pcnt_in          = n_ent;
               end else begin
                  // write back '&' and the held letters, then the breaking byte unless it opens an escape or entity
                  cand[0] = CH_AMP;
                  for (int k = 0; k < ENTITY_MAX_LEN - 1; k++) begin
                     if (PCNT_W'(k) < pcnt_ff) cand[k + 1] = pend_ff[k];
                  end
                  ncand   = n_ent;
                  mode_in = M_NORMAL;
                  pcnt_in = '0;
                  if (c == CH_BSLASH && !last) begin
                     mode_in = M_ESCAPE;
                  end else if (c == CH_AMP && !last) begin
                     mode_in = M_ENTITY;
                  end else begin
                     cand[ncand] = c;
                     ncand       = ncand + 3'd1;
                  end
               end
            end
            M_ESCAPE: begin
               mode_in = M_NORMAL;
               ncand   = 3'd1;
               unique case (c)
                  CH_LC_B:  cand[0] = CH_BS;
                  CH_LC_F:  cand[0] = CH_FF;
                  CH_LC_N:  cand[0] = CH_LF;
                  CH_LC_R:  cand[0] = CH_CR;
                  CH_LC_T:  cand[0] = CH_TAB;
                  CH_QUOTE, CH_BSLASH, CH_SLASH: cand[0] = c;
                  CH_LC_U: begin
                     mode_in = M_HEX1;
                     pcnt_in = '0;
                     hex_in  = '0;
                     ncand   = '0;
                  end
                  default: begin
                     cand[0] = CH_BSLASH;
                     cand[1] = c;
                     ncand   = 3'd2;
                  end
               endcase
            end
            M_HEX1, M_HEX2: begin
               if (!hex_v[4]) begin
                  mode_in = M_FAILED;
               end else begin
                  hex_in  = acc;
                  pcnt_in = pcnt_ff + 3'd1;
                  if (pcnt_ff == 3'd3) begin
                     pcnt_in = '0;
                     if (mode_ff == M_HEX1) begin
                        if (acc >= 16'hD800 && acc <= 16'hDBFF) begin
                           hsur_in = acc[9:0];
                           mode_in = M_SURR_BS;
                        end else if (acc >= 16'hDC00 && acc <= 16'hDFFF) begin
                           mode_in = M_FAILED;
                        end else begin
                           utf_cp  = {5'd0, acc};
                           utf_go  = 1'b1;
                           mode_in = M_NORMAL;
                        end
                     end else if (acc >= 16'hDC00 && acc <= 16'hDFFF) begin
                        utf_cp  = {1'b0, hsur_ff, acc[9:0]} + 21'h10000;
                        utf_go  = 1'b1;
                        mode_in = M_NORMAL;
                     end else begin
                        mode_in = M_FAILED;
                     end
                  end
               end
            end
            M_SURR_BS: mode_in = (c == CH_BSLASH) ? M_SURR_U : M_FAILED;
            M_SURR_U: begin
               if (c == CH_LC_U) begin
                  mode_in = M_HEX2;
                  pcnt_in = '0;
                  hex_in  = '0;
               end else begin
                  mode_in = M_FAILED;
               end
            end
            M_FAILED: mode_in = M_FAILED;
         endcase

         if (utf_go) begin
            if (utf_cp < 21'h80) begin
               cand[0] = utf_cp[7:0];
               ncand   = 3'd1;
            end else if (utf_cp < 21'h800) begin
               cand[0] = {3'b110, utf_cp[10:6]};
               cand[1] = {2'b10, utf_cp[5:0]};
               ncand   = 3'd2;
            end else if (utf_cp < 21'h10000) begin
               cand[0] = {4'b1110, utf_cp[15:12]};
               cand[1] = {2'b10, utf_cp[11:6]};
               cand[2] = {2'b10, utf_cp[5:0]};
               ncand   = 3'd3;
            end else begin
               cand[0] = {5'b11110, utf_cp[20:18]};
               cand[1] = {2'b10, utf_cp[17:12]};
               cand[2] = {2'b10, utf_cp[11:6]};
               cand[3] = {2'b10, utf_cp[5:0]};
               ncand   = 3'd4;
            end
         end

         // a text that ends inside a unicode sequence fails
         if (last && (mode_in == M_HEX1 || mode_in == M_SURR_BS ||
                      mode_in == M_SURR_U || mode_in == M_HEX2)) begin
            mode_in = M_FAILED;
         end
      end
   end

   // clip the burst at the remaining capacity
   assign room     = cap_ff - wcnt_ff;
   assign emitted  = (room < {13'd0, ncand}) ? room[BCNT_W-1:0] : ncand;
   assign wcnt_sum = wcnt_ff + {13'd0, emitted};
   assign fail_end = (mode_in == M_FAILED);

   assign push            = accept && (emitted != '0 || last);
   assign push_cmd.bytes  = cand;
   assign push_cmd.count  = emitted;
   assign push_cmd.is_end = last;
   assign push_cmd.error  = last && fail_end;
   assign push_cmd.length = (last && !fail_end) ? wcnt_sum : 16'd0;

   always_comb begin
      wcnt_in = wcnt_sum;
      if (last) wcnt_in = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= M_NORMAL;
         pcnt_ff <= '0;
         wcnt_ff <= '0;
         cap_ff  <= 16'd4095;
      end else begin
         if (csr_wr_en) cap_ff <= csr_wr_data;
         if (accept) begin
            mode_ff <= last ? M_NORMAL : mode_in;
            pcnt_ff <= last ? '0 : pcnt_in;
            wcnt_ff <= wcnt_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pend_ff <= pend_in;
         hex_ff  <= hex_in;
         hsur_ff <= hsur_in;
      end
   end

endmodule

// ===== rtl/tedec_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tedec_queue: command queue
// Small FIFO of decoded commands between the classifier and the beat
// generator.
// ----------------------------------------------------------------------------
module tedec_queue #(
   parameter int DEPTH = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  tedec_pkg::cmd_type   push_cmd,
   output logic                 full,
   input  logic                 pop,
   output tedec_pkg::cmd_type   head,
   output logic                 not_empty
);
   import tedec_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   cmd_type           slot_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ff, wr_in;
   logic [PTR_W-1:0]  rd_ff, rd_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;

   assign full      = (cnt_ff == CNT_W'(DEPTH));
   assign not_empty = (cnt_ff != '0);
   assign head      = slot_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) wr_in = (wr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      if (pop)  rd_in = (rd_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      if (push && !pop) cnt_in = cnt_ff + 1'b1;
      if (pop && !push) cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ff] <= push_cmd;
   end

endmodule

// ===== rtl/tedec_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tedec_back: beat generator
// Unpacks each queued command into result beats, one per cycle while the
// receiver is ready, through a registered output stage.
// ----------------------------------------------------------------------------
module tedec_back (
   input  logic                 clock,
   input  logic                 reset,
   input  tedec_pkg::cmd_type   head,
   input  logic                 q_valid,
   output logic                 pop,
   tedec_rsp_if.source          rsp
);
   import tedec_pkg::*;

   cmd_type             work_ff, work_in;
   logic                busy_ff, busy_in;
   logic [BCNT_W-1:0]   idx_ff, idx_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [7:0]          byte_ff, byte_in;
   logic                end_ff, end_in;
   logic                err_ff, err_in;
   logic [15:0]         len_ff, len_in;

   logic                load;
   logic                is_data;
   logic                final_beat;

   assign load       = busy_ff && (!rsp_valid_ff || rsp.ready);
   assign is_data    = idx_ff < work_ff.count;
   assign final_beat = ({1'b0, idx_ff} + 4'd1) ==
                       ({1'b0, work_ff.count} + {3'd0, work_ff.is_end});

   always_comb begin
      work_in      = work_ff;
      busy_in      = busy_ff;
      idx_in       = idx_ff;
      pop          = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      byte_in      = byte_ff;
      end_in       = end_ff;
      err_in       = err_ff;
      len_in       = len_ff;

      if (load) begin
         rsp_valid_in = 1'b1;
         if (is_data) begin
            byte_in = work_ff.bytes[idx_ff];
            end_in  = 1'b0;
            err_in  = 1'b0;
            len_in  = '0;
         end else begin
            byte_in = '0;
            end_in  = 1'b1;
            err_in  = work_ff.error;
            len_in  = work_ff.length;
         end
      end

      // refill the work slot as its last beat leaves
      if (!busy_ff || (load && final_beat)) begin
         if (q_valid) begin
            pop     = 1'b1;
            work_in = head;
            idx_in  = '0;
            busy_in = 1'b1;
         end else begin
            busy_in = 1'b0;
         end
      end else if (load) begin
         idx_in = idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
      idx_ff  <= idx_in;
      byte_ff <= byte_in;
      end_ff  <= end_in;
      err_ff  <= err_in;
      len_ff  <= len_in;
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.out_byte   = byte_ff;
   assign rsp.is_end     = end_ff;
   assign rsp.error      = err_ff;
   assign rsp.out_length = len_ff;

endmodule

// ===== rtl/text_escape_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_escape_decoder: streaming unescaper for JSON-style text with entities
// Decodes C escapes, \uXXXX (with surrogate pairs) to UTF-8 and five XML
// entities, one source byte per beat, with an output capacity limit.
// ----------------------------------------------------------------------------
// Usage:
//   req_bus  : source text, one byte per beat; in_last marks the final byte.
//   rsp_bus  : one beat per decoded byte, then one end beat per text with
//              is_end set, error and out_length (0 when error is set).
//   csr_wr_*: output capacity in bytes; write only between items.
// Throughput: one source byte per cycle while the command queue has room.
//   A source byte yields up to six data beats (a broken entity) plus the end
//   beat; the beat generator delivers one beat per cycle while the receiver
//   is ready, so sustained input rate is bounded by the output beat count,
//   buffered by QUEUE_DEPTH commands.
// Path: an accepted byte's command is written to the queue, taken into the
//   work slot of the beat generator, then registered in the output stage.
// Reset: synchronous; returns to plain text mode, empties the queue and the
//   output stage, and sets the capacity to 4095.
// Stall: a stalled receiver holds the output stage; the queue then fills and
//   req_bus.ready drops until beats drain.
// ----------------------------------------------------------------------------
module text_escape_decoder #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   tedec_req_if.sink   req_bus,
   tedec_rsp_if.source rsp_bus,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);
   import tedec_pkg::*;

   // front to queue
   logic    push;
   cmd_type push_cmd;
   logic    q_full;

   // queue to back
   logic    pop;
   cmd_type head;
   logic    q_valid;

   // classify each accepted byte and pack its output into one command
   tedec_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req         (req_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .q_full      (q_full),
      .push        (push),
      .push_cmd    (push_cmd)
   );

   // decouple classification from delivery
   tedec_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (push_cmd),
      .full      (q_full),
      .pop       (pop),
      .head      (head),
      .not_empty (q_valid)
   );

   // advance through the commands beat by beat
   tedec_back u_back (
      .clock   (clock),
      .reset   (reset),
      .head    (head),
      .q_valid (q_valid),
      .pop     (pop),
      .rsp     (rsp_bus)
   );

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the text escape decoder
// Streams escaped texts into the decoder and compares every decoded beat with
// a cycle-free model of the unescaper: entities, C escapes, \uXXXX with
// surrogate pairs, broken escapes and the output capacity limit. Both ends
// idle at random, and one long receiver stall backs the decoder up.
// ----------------------------------------------------------------------------
module tb_top;
   import tedec_pkg::*;

   localparam int          QUIET_LIMIT   = 3000;  // cycles without any beat
   localparam int          HOLD_CYCLES   = 400;   // long receiver stall
   localparam int          SETTLE_CYCLES = 12;    // covers the decoder latency
   localparam logic [15:0] CAP_RESET     = 16'd4095;

   typedef struct {
      logic [7:0] data;
      logic       last;
   } src_beat_type;

   typedef struct {
      logic [7:0]  data;
      logic        is_end;
      logic        err;
      logic [15:0] len;
   } dec_beat_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_wr_en;
   logic [15:0] csr_wr_data;

   tedec_req_if req_bus ();
   tedec_rsp_if rsp_bus ();

   text_escape_decoder DUT (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Source bytes waiting for the driver, decoded beats waiting for the DUT,
   // and the text under construction.
   src_beat_type src_q [$];
   dec_beat_type decoded_q [$];
   logic [7:0]   text_buf [$];

   int unsigned beats_sent  = 0;
   int unsigned beats_taken = 0;
   int          mismatches  = 0;
   int          quiet       = 0;
   logic        req_fire    = 1'b0;
   logic        steady;                 // no idling on either side
   int          hold_asked;
   int          hold_given  = 0;
   int          hold_left   = 0;

   // Decoder model state
   mode_type    dm_mode;
   logic [7:0]  ent_held [ENTITY_MAX_LEN];
   int          held_n;                 // entity letters held or hex digits taken
   logic [15:0] hex_acc;
   logic [15:0] hi_surr;
   logic [15:0] out_count;
   logic [15:0] capacity;

   string       ent_text [5] = '{"quot;", "apos;", "amp;", "lt;", "gt;"};
   logic [7:0]  ent_char [5] = '{8'h22, 8'h27, 8'h26, 8'h3C, 8'h3E};
   string       esc_set      = "bfnrt\"\\/";

   // ------------------------------------------------------------------------
   // Decoder model
   // ------------------------------------------------------------------------
   function automatic void clear_text_state();
      dm_mode   = M_NORMAL;
      held_n    = 0;
      hex_acc   = '0;
      hi_surr   = '0;
      out_count = '0;
   endfunction

   // Drop the byte once the capacity is used up.
   function automatic void put_byte(logic [7:0] b);
      dec_beat_type r;
      if (out_count < capacity) begin
         r.data   = b;
         r.is_end = 1'b0;
         r.err    = 1'b0;
         r.len    = '0;
         decoded_q.push_back(r);
         out_count++;
      end
   endfunction

   function automatic void put_utf8(int unsigned cp);
      if (cp < 32'h80) begin
         put_byte(8'(cp));
      end else if (cp < 32'h800) begin
         put_byte(8'hC0 | 8'(cp >> 6));
         put_byte(8'h80 | 8'(cp & 32'h3F));
      end else if (cp < 32'h10000) begin
         put_byte(8'hE0 | 8'(cp >> 12));
         put_byte(8'h80 | 8'((cp >> 6) & 32'h3F));
         put_byte(8'h80 | 8'(cp & 32'h3F));
      end else begin
         put_byte(8'hF0 | 8'(cp >> 18));
         put_byte(8'h80 | 8'((cp >> 12) & 32'h3F));
         put_byte(8'h80 | 8'((cp >> 6) & 32'h3F));
         put_byte(8'h80 | 8'(cp & 32'h3F));
      end
   endfunction

   function automatic logic [7:0] fold(logic [7:0] b);
      return (b >= 8'h41 && b <= 8'h5A) ? b + 8'd32 : b;
   endfunction

   function automatic int hex_digit(logic [7:0] c);
      if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
      if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h41 + 10;
      if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h61 + 10;
      return -1;
   endfunction

   function automatic void take_plain(logic [7:0] c, logic last);
      if (c == CH_BSLASH) begin
         if (last) put_byte(c);
         else dm_mode = M_ESCAPE;
      end else if (c == CH_AMP) begin
         if (last) put_byte(c);
         else begin
            dm_mode = M_ENTITY;
            held_n  = 0;
         end
      end else begin
         put_byte(c);
      end
   endfunction

   // Grow the held letters while some entity still matches; on a full match
   // write its character, otherwise write '&' and the letters back unchanged
   // and treat the breaking byte as plain text.
   function automatic void take_entity(logic [7:0] c, logic last);
      int         n;
      bit         partial;
      bit         ok;
      logic [7:0] b;
      logic [7:0] pat;
      n       = held_n + 1;
      partial = 1'b0;
      for (int i = 0; i < 5; i++) begin
         ok = (n <= ent_text[i].len());
         for (int k = 0; ok && k < n; k++) begin
            b   = (k < held_n) ? ent_held[k] : c;
            pat = ent_text[i][k];
            if (k == 0 ? (b != pat) : (fold(b) != pat)) ok = 1'b0;
         end
         if (ok) begin
            if (n == ent_text[i].len()) begin
               put_byte(ent_char[i]);
               dm_mode = M_NORMAL;
               held_n  = 0;
               return;
            end
            partial = 1'b1;
         end
      end
      if (partial && !last && held_n < ENTITY_MAX_LEN) begin
         ent_held[held_n] = c;
         held_n           = n;
         return;
      end
      put_byte(CH_AMP);
      for (int k = 0; k < held_n; k++) put_byte(ent_held[k]);
      dm_mode = M_NORMAL;
      held_n  = 0;
      take_plain(c, last);
   endfunction

   function automatic void take_escape(logic [7:0] c);
      dm_mode = M_NORMAL;
      case (c)
         CH_LC_B: put_byte(CH_BS);
         CH_LC_F: put_byte(CH_FF);
         CH_LC_N: put_byte(CH_LF);
         CH_LC_R: put_byte(CH_CR);
         CH_LC_T: put_byte(CH_TAB);
         CH_QUOTE, CH_BSLASH, CH_SLASH: put_byte(c);
         CH_LC_U: begin
            dm_mode = M_HEX1;
            held_n  = 0;
            hex_acc = '0;
         end
         default: begin
            put_byte(CH_BSLASH);
            put_byte(c);
         end
      endcase
   endfunction

   function automatic void take_hex(logic [7:0] c);
      int          d;
      logic [15:0] v;
      d = hex_digit(c);
      if (d < 0) begin
         dm_mode = M_FAILED;
         return;
      end
      hex_acc = {hex_acc[11:0], d[3:0]};
      held_n++;
      if (held_n < 4) return;
      held_n = 0;
      v      = hex_acc;
      if (dm_mode == M_HEX1) begin
         if (v >= 16'hD800 && v <= 16'hDBFF) begin
            hi_surr = v;
            dm_mode = M_SURR_BS;
         end else if (v >= 16'hDC00 && v <= 16'hDFFF) begin
            dm_mode = M_FAILED;
         end else begin
            put_utf8(32'(v));
            dm_mode = M_NORMAL;
         end
      end else if (v >= 16'hDC00 && v <= 16'hDFFF) begin
         put_utf8(32'h10000 + ((32'(hi_surr) - 32'hD800) << 10) + (32'(v) - 32'hDC00));
         dm_mode = M_NORMAL;
      end else begin
         dm_mode = M_FAILED;
      end
   endfunction

   // One accepted source byte: queue the beats it must produce.
   function automatic void decode_byte(logic [7:0] c, logic last);
      dec_beat_type r;
      if (dm_mode != M_FAILED && out_count < capacity) begin
         case (dm_mode)
            M_NORMAL:       take_plain(c, last);
            M_ENTITY:       take_entity(c, last);
            M_ESCAPE:       take_escape(c);
            M_HEX1, M_HEX2: take_hex(c);
            M_SURR_BS:      dm_mode = (c == CH_BSLASH) ? M_SURR_U : M_FAILED;
            default: begin
               if (c == CH_LC_U) begin
                  dm_mode = M_HEX2;
                  held_n  = 0;
                  hex_acc = '0;
               end else begin
                  dm_mode = M_FAILED;
               end
            end
         endcase
         // a text that ends inside a unicode sequence is broken
         if (last && dm_mode >= M_HEX1 && dm_mode <= M_HEX2) dm_mode = M_FAILED;
      end
      if (last) begin
         r.data   = '0;
         r.is_end = 1'b1;
         r.err    = (dm_mode == M_FAILED);
         r.len    = r.err ? 16'd0 : out_count;
         decoded_q.push_back(r);
         clear_text_state();
      end
   endfunction

   function automatic void check_beat();
      dec_beat_type want;
      if (decoded_q.size() == 0) begin
         $error("unexpected beat: out_byte %02h is_end %0b error %0b out_length %0d",
                rsp_bus.out_byte, rsp_bus.is_end, rsp_bus.error, rsp_bus.out_length);
         mismatches++;
         return;
      end
      want = decoded_q.pop_front();
      if (rsp_bus.out_byte !== want.data) begin
         $error("out_byte: expected %02h, got %02h", want.data, rsp_bus.out_byte);
         mismatches++;
      end
      if (rsp_bus.is_end !== want.is_end) begin
         $error("is_end: expected %0b, got %0b", want.is_end, rsp_bus.is_end);
         mismatches++;
      end
      if (rsp_bus.error !== want.err) begin
         $error("error: expected %0b, got %0b", want.err, rsp_bus.error);
         mismatches++;
      end
      if (rsp_bus.out_length !== want.len) begin
         $error("out_length: expected %0d, got %0d", want.len, rsp_bus.out_length);
         mismatches++;
      end
   endfunction

   // ------------------------------------------------------------------------
   // Text builder
   // ------------------------------------------------------------------------
   function automatic void add_str(string s);
      for (int k = 0; k < s.len(); k++) text_buf.push_back(s[k]);
   endfunction

   // Hex letters come in either case.
   function automatic logic [7:0] hex_char(logic [3:0] n);
      if (n < 4'd10) return 8'h30 + 8'(n);
      return (($urandom_range(1) != 0) ? 8'h41 : 8'h61) + 8'(n) - 8'd10;
   endfunction

   function automatic void add_unicode(logic [15:0] v);
      add_str("\\u");
      for (int s = 12; s >= 0; s -= 4) text_buf.push_back(hex_char(v[s +: 4]));
   endfunction

   function automatic logic [15:0] high_half();
      case ($urandom_range(3))
         0:       return 16'hD800;
         1:       return 16'hDBFF;
         default: return 16'hD800 + 16'($urandom_range(16'h3FF));
      endcase
   endfunction

   function automatic logic [15:0] low_half();
      case ($urandom_range(3))
         0:       return 16'hDC00;
         1:       return 16'hDFFF;
         default: return 16'hDC00 + 16'($urandom_range(16'h3FF));
      endcase
   endfunction

   function automatic void add_token();
      int          start;
      int          i;
      logic [7:0]  ch;
      logic [15:0] cp;
      case ($urandom_range(99)) inside
         [0:29]: begin
            text_buf.push_back(8'($urandom_range(255)));
         end
         [30:44]: begin
            // entity with random case on the tail, sometimes damaged
            i     = $urandom_range(4);
            start = text_buf.size();
            text_buf.push_back(CH_AMP);
            for (int k = 0; k < ent_text[i].len(); k++) begin
               ch = ent_text[i][k];
               if (k > 0 && ch >= 8'h61 && ch <= 8'h7A && $urandom_range(1) != 0)
                  ch = ch - 8'd32;
               text_buf.push_back(ch);
            end
            case ($urandom_range(5))
               0: text_buf[start + $urandom_range(1, ent_text[i].len())] =
                     8'($urandom_range(8'h41, 8'h7A));
               1: text_buf[start + 1] = text_buf[start + 1] - 8'd32;
               default: ;
            endcase
         end
         [45:59]: begin
            i = $urandom_range(9);
            text_buf.push_back(CH_BSLASH);
            text_buf.push_back(i < 8 ? 8'(esc_set[i]) : 8'($urandom_range(255)));
         end
         [60:74]: begin
            case ($urandom_range(7))
               0: cp = 16'h0000;
               1: cp = 16'h007F;
               2: cp = 16'h0080;
               3: cp = 16'h07FF;
               4: cp = 16'h0800;
               5: cp = 16'hFFFF;
               default: begin
                  cp = 16'($urandom_range(16'hFFFF));
                  if (cp >= 16'hD800 && cp <= 16'hDFFF) cp = cp ^ 16'h4000;
               end
            endcase
            add_unicode(cp);
         end
         [75:84]: begin
            add_unicode(high_half());
            add_unicode(low_half());
         end
         [85:91]: begin
            // broken unicode escapes
            case ($urandom_range(4))
               0: begin
                  add_str("\\u1");
                  text_buf.push_back(($urandom_range(1) != 0) ? 8'h47 : 8'h20);
               end
               1: add_unicode(low_half());
               2: begin
                  add_unicode(high_half());
                  add_str("x");
               end
               3: begin
                  add_unicode(high_half());
                  add_str("\\n");
               end
               default: begin
                  add_unicode(high_half());
                  add_unicode(16'h0041);
               end
            endcase
         end
         default: begin
            text_buf.push_back(($urandom_range(1) != 0) ? CH_BSLASH : CH_AMP);
         end
      endcase
   endfunction

   // Hand the finished text to the driver, in_last on its final byte.
   function automatic void flush_text();
      src_beat_type b;
      for (int k = 0; k < text_buf.size(); k++) begin
         b.data = text_buf[k];
         b.last = (k == text_buf.size() - 1);
         src_q.push_back(b);
      end
      text_buf.delete();
   endfunction

   // Random texts until about 'budget' bytes are queued. Some texts are cut
   // short at a random point, so that some end inside an entity or an escape.
   function automatic void queue_texts(int budget);
      int added;
      int cut;
      added = 0;
      while (added < budget) begin
         repeat ($urandom_range(1, 6)) add_token();
         if ($urandom_range(9) == 0 && text_buf.size() > 1) begin
            cut = $urandom_range(1, text_buf.size() - 1);
            while (text_buf.size() > cut) void'(text_buf.pop_back());
         end
         added += text_buf.size();
         flush_text();
      end
   endfunction

   // ------------------------------------------------------------------------
   // Driver: offer the next byte at the falling edge once the current beat
   // has gone through; idle now and then unless the run is in a steady phase.
   // ------------------------------------------------------------------------
   always @(negedge clock) begin : driver
      src_beat_type beat;
      if (reset) begin
         req_bus.valid   <= 1'b0;
         req_bus.in_byte <= '0;
         req_bus.in_last <= 1'b0;
      end else if (!req_bus.valid || req_fire) begin
         if (src_q.size() != 0 && (steady || $urandom_range(99) >= 6)) begin
            beat = src_q.pop_front();
            beats_sent++;
            req_bus.valid   <= 1'b1;
            req_bus.in_byte <= beat.data;
            req_bus.in_last <= beat.last;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // Receiver: random back-pressure, plus one long hold-off on request so the
   // decoder queue fills and the source side stalls.
   always @(negedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_bus.ready <= 1'b0;
         hold_left     <= hold_left - 1;
      end else if (hold_asked != hold_given) begin
         rsp_bus.ready <= 1'b0;
         hold_given    <= hold_given + 1;
         hold_left     <= HOLD_CYCLES;
      end else begin
         rsp_bus.ready <= steady || $urandom_range(99) >= 6;
      end
   end

   // Monitor: capacity writes and source beats feed the model, decoded beats
   // are checked against it; the watchdog ends a run that stops moving.
   always @(posedge clock) begin
      if (reset) begin
         req_fire <= 1'b0;
         quiet    <= 0;
         capacity = CAP_RESET;
         clear_text_state();
      end else begin
         req_fire <= req_bus.valid && req_bus.ready;
         if (csr_wr_en) capacity = csr_wr_data;
         if (req_bus.valid && req_bus.ready) begin
            beats_taken++;
            decode_byte(req_bus.in_byte, req_bus.in_last);
         end
         if (rsp_bus.valid && rsp_bus.ready) check_beat();
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
            quiet <= 0;
         end else if (quiet >= QUIET_LIMIT) begin
            $error("watchdog: no beat for %0d cycles, %0d beats outstanding",
                   QUIET_LIMIT, decoded_q.size());
            $display("[FAIL] regression broken");
            $finish;
         end else begin
            quiet <= quiet + 1;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Sequencing
   // ------------------------------------------------------------------------
   // Wait until every byte is taken and every beat is back, then let the
   // pipeline settle.
   task automatic wait_idle();
      while (src_q.size() != 0 || beats_sent != beats_taken || decoded_q.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_capacity(logic [15:0] value);
      wait_idle();
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   initial begin
      reset           = 1'b1;
      csr_wr_en       = 1'b0;
      csr_wr_data     = '0;
      steady          = 1'b0;
      hold_asked      = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed texts at the reset capacity: mixed-case entity, the highest
      // surrogate pair, extreme bytes with an unknown escape, a partial
      // entity cut by a trailing backslash, and a bad hex digit.
      add_str("&aPOs;");
      flush_text();
      add_str("\\uDBFF\\uDfFf");
      flush_text();
      text_buf.push_back(8'hFF);
      text_buf.push_back(8'h00);
      add_str("\\q&l\\");
      flush_text();
      add_str("\\uZ");
      flush_text();

      // Capacity of one: at most one byte per text, the rest dropped.
      write_capacity(16'd1);
      queue_texts(10);

      // Largest capacity, no idling on either side.
      write_capacity(16'hFFFF);
      steady = 1'b1;
      queue_texts(45);
      wait_idle();
      steady = 1'b0;

      // Small capacity so texts run into the limit mid-sequence.
      write_capacity(16'($urandom_range(2, 12)));
      queue_texts(20);

      // Back to the reset value; hold the receiver off while the driver keeps
      // offering bytes.
      write_capacity(CAP_RESET);
      queue_texts(55);
      hold_asked = hold_asked + 1;

      wait_idle();
      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
